// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the core's controller.
// Both expect clk and rst in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/acc8_pkg.sv =====
// ----------------------------------------------------------------------------
// acc8_pkg
// Types, opcodes and codes shared by the 8-bit accumulator core.
// ----------------------------------------------------------------------------
package acc8_pkg;

  localparam int ADDR_W          = 8;
  localparam int MEM_DEPTH       = 256;
  localparam int STACK_DEPTH_DEF = 16;
  localparam logic [15:0] MAX_STEPS_RST = 16'hFFFF;

  // opcodes
  localparam logic [7:0] OP_MOV_ACC_A  = 8'h08;
  localparam logic [7:0] OP_MOV_A_ACC  = 8'h10;
  localparam logic [7:0] OP_LDI        = 8'h18;
  localparam logic [7:0] OP_LDM        = 8'h20;
  localparam logic [7:0] OP_MOV_DP_ACC = 8'h28;
  localparam logic [7:0] OP_STM        = 8'h30;
  localparam logic [7:0] OP_INV        = 8'h38;
  localparam logic [7:0] OP_AND        = 8'h40;
  localparam logic [7:0] OP_ADD        = 8'h48;
  localparam logic [7:0] OP_JMP        = 8'h50;
  localparam logic [7:0] OP_JZ         = 8'h58;
  localparam logic [7:0] OP_JN         = 8'h60;
  localparam logic [7:0] OP_JC         = 8'h68;
  localparam logic [7:0] OP_CALL       = 8'h70;
  localparam logic [7:0] OP_RET        = 8'h78;
  localparam logic [7:0] OP_XOR        = 8'h80;
  localparam logic [7:0] OP_SLL        = 8'h88;
  localparam logic [7:0] OP_SRL        = 8'h90;
  localparam logic [7:0] OP_OR         = 8'h98;
  localparam logic [7:0] OP_SUB        = 8'hA0;

  typedef enum logic [1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_EXEC    = 2'd1,
    FUNC_READ    = 2'd2,
    FUNC_RESTART = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    STOP_NONE      = 3'd0,
    STOP_RET_EMPTY = 3'd1,
    STOP_BAD_OP    = 3'd2,
    STOP_PC_RANGE  = 3'd3,
    STOP_STEPS     = 3'd4,
    STOP_OVERFLOW  = 3'd5
  } stop_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_OP,
    S_IMM,
    S_LOAD,
    S_RET,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    MSEL_ITEM,
    MSEL_PC,
    MSEL_DPTR,
    MSEL_CLEAR
  } mem_sel_t;

  typedef enum logic [1:0] {
    WSEL_ITEM,
    WSEL_ACC,
    WSEL_ZERO
  } wsel_t;

  // controller -> datapath
  typedef struct packed {
    logic       latch_item;
    mem_sel_t   mem_sel;
    wsel_t      wsel;
    logic       mem_rd;
    logic       mem_wr;
    logic       clr_step;
    logic       pc_inc;
    logic       restart;
    logic       set_stop;
    stop_t      stop_val;
    logic       latch_op;
    logic       step_inc;
    logic [7:0] op;
    logic       alu_exec;
    logic       imm_exec;
    logic       load_acc;
    logic       pop;
    logic       ret_load;
    logic       res_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    func_t      func;
    logic [7:0] mem_q;
    logic [7:0] last_op;
    logic       halted;
    logic       step_limit;
    logic       pc_oob;
    logic       stack_empty;
    logic       stack_full;
    logic       out_busy;
    logic       clr_last;
  } sts_t;

  function automatic logic known_op(input logic [7:0] op);
    return (op[2:0] == 3'b000) && (op >= OP_MOV_ACC_A) && (op <= OP_SUB);
  endfunction

endpackage

// ===== rtl/acc8_ctrl.sv =====
// ----------------------------------------------------------------------------
// acc8_ctrl
// Sequencer: memory clear after reset, item dispatch, instruction fetch,
// operand fetch and result hand-off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module acc8_ctrl
  import acc8_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.mem_sel  = MSEL_ITEM;
    cmd.wsel     = WSEL_ITEM;
    cmd.stop_val = STOP_NONE;
    cmd.op       = sts.last_op;
    item_stall   = 1'b1;

    unique case (state)
      S_CLEAR: begin
        cmd.mem_wr   = 1'b1;
        cmd.mem_sel  = MSEL_CLEAR;
        cmd.wsel     = WSEL_ZERO;
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end

      S_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.latch_item = 1'b1;
          state_next     = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        state_next = S_DONE;
        unique case (sts.func)
          FUNC_WRITE: cmd.mem_wr = 1'b1;
          FUNC_READ:  cmd.mem_rd = 1'b1;
          FUNC_RESTART: cmd.restart = 1'b1;
          FUNC_EXEC: begin
            if (sts.halted) begin
              // nothing to do
            end else if (sts.step_limit) begin
              cmd.set_stop = 1'b1;
              cmd.stop_val = STOP_STEPS;
            end else if (sts.pc_oob) begin
              cmd.set_stop = 1'b1;
              cmd.stop_val = STOP_PC_RANGE;
            end else begin
              cmd.mem_rd  = 1'b1;
              cmd.mem_sel = MSEL_PC;
              cmd.pc_inc  = 1'b1;
              state_next  = S_OP;
            end
          end
          default: ;
        endcase
      end

      S_OP: begin
        // opcode arrives from memory this cycle
        cmd.op       = sts.mem_q;
        cmd.latch_op = 1'b1;
        state_next   = S_DONE;
        if (!known_op(sts.mem_q)) begin
          cmd.set_stop = 1'b1;
          cmd.stop_val = STOP_BAD_OP;
        end else begin
          cmd.step_inc = 1'b1;
          unique case (sts.mem_q) inside
            OP_LDI, OP_JMP, OP_JZ, OP_JN, OP_JC, OP_CALL: begin
              if (sts.pc_oob) begin
                cmd.set_stop = 1'b1;
                cmd.stop_val = STOP_PC_RANGE;
              end else begin
                cmd.mem_rd  = 1'b1;
                cmd.mem_sel = MSEL_PC;
                cmd.pc_inc  = 1'b1;
                state_next  = S_IMM;
              end
            end
            OP_LDM: begin
              cmd.mem_rd  = 1'b1;
              cmd.mem_sel = MSEL_DPTR;
              state_next  = S_LOAD;
            end
            OP_STM: begin
              cmd.mem_wr   = 1'b1;
              cmd.mem_sel  = MSEL_DPTR;
              cmd.wsel     = WSEL_ACC;
              cmd.alu_exec = 1'b1;
            end
            OP_RET: begin
              if (sts.stack_empty) begin
                cmd.set_stop = 1'b1;
                cmd.stop_val = STOP_RET_EMPTY;
              end else begin
                cmd.pop    = 1'b1;
                state_next = S_RET;
              end
            end
            default: cmd.alu_exec = 1'b1;
          endcase
        end
      end

      S_IMM: begin
        cmd.imm_exec = 1'b1;
        if (sts.last_op == OP_CALL && sts.stack_full) begin
          cmd.set_stop = 1'b1;
          cmd.stop_val = STOP_OVERFLOW;
        end
        state_next = S_DONE;
      end

      S_LOAD: begin
        cmd.load_acc = 1'b1;
        state_next   = S_DONE;
      end

      S_RET: begin
        cmd.ret_load = 1'b1;
        state_next   = S_DONE;
      end

      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // checks
  `ASSERT_IMPL(a_res_free, cmd.res_load, !sts.out_busy, "result loaded over a held word")
  `ASSERT_IMPL(a_mem_port, 1'b1, !(cmd.mem_rd && cmd.mem_wr), "memory read and write together")
  `ASSERT_IMPL(a_stop_once, cmd.set_stop, !sts.halted, "stop cause set while halted")
  `ASSERT_IMPL(a_imm_seq, state == S_IMM, $past(state) == S_OP, "operand fetch out of order")

endmodule

// ===== rtl/acc8_dp.sv =====
// ----------------------------------------------------------------------------
// acc8_dp
// Datapath: architectural registers, ALU, unified memory, return stack
// and the result word register.
// ----------------------------------------------------------------------------
module acc8_dp
  import acc8_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        func,
  input  logic [ADDR_W-1:0] address,
  input  logic [7:0]        write_data,
  input  logic              cfg_valid,
  input  logic [15:0]       max_steps,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [7:0]        accumulator,
  output logic [7:0]        operand_reg,
  output logic [7:0]        data_pointer,
  output logic [8:0]        prog_counter,
  output logic              zero_flag,
  output logic              negative_flag,
  output logic              carry_flag,
  output logic              halted,
  output logic [2:0]        stop_cause,
  output logic [7:0]        last_op,
  output logic [7:0]        read_data
);

  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam int SP_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // item latch
  func_t             item_func;
  logic [ADDR_W-1:0] item_addr;
  logic [7:0]        item_wdata;

  // architectural state
  logic [7:0]   acc, opnd, dptr, op_reg;
  logic [8:0]   pc;
  logic         flag_z, flag_n, flag_c;
  stop_t        stop;
  logic [15:0]  step_cnt, steps_limit;
  logic [DEPTH_W-1:0] depth, depth_m1;
  logic [ADDR_W-1:0]  clr_cnt;

  // memories
  logic [7:0] mem [MEM_DEPTH];
  logic [7:0] mem_q;
  logic [8:0] stack [STACK_DEPTH];
  logic [8:0] stack_q;

  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata;
  logic              stack_full, push_en;

  // ALU results
  logic [7:0] alu_val;
  logic       alu_c;
  logic       dst_acc, dst_a, dst_dptr;
  logic [8:0] add_w, sub_w, sll_w, srl_w;

  assign depth_m1   = depth - 1'b1;
  assign stack_full = (depth == DEPTH_W'(STACK_DEPTH));
  assign push_en    = cmd.imm_exec && (cmd.op == OP_CALL) && !stack_full;

  // memory address and write data select
  always_comb begin
    case (cmd.mem_sel)
      MSEL_ITEM:  mem_addr = item_addr;
      MSEL_PC:    mem_addr = pc[ADDR_W-1:0];
      MSEL_DPTR:  mem_addr = dptr;
      MSEL_CLEAR: mem_addr = clr_cnt;
      default:    mem_addr = item_addr;
    endcase
    case (cmd.wsel)
      WSEL_ITEM: mem_wdata = item_wdata;
      WSEL_ACC:  mem_wdata = acc;
      default:   mem_wdata = 8'h00;
    endcase
  end

  // single-port memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[mem_addr] <= mem_wdata;
    if (cmd.mem_rd) mem_q <= mem[mem_addr];
  end

  // return stack, registered read of the top entry
  always_ff @(posedge clk) begin
    if (push_en) stack[depth[SP_W-1:0]] <= pc;
    if (cmd.pop) stack_q <= stack[depth_m1[SP_W-1:0]];
  end

  // ALU for register and flag-setting operations
  assign add_w = {1'b0, acc} + {1'b0, opnd};
  assign sub_w = {1'b0, acc} - {1'b0, opnd};
  assign sll_w = {1'b0, acc} << opnd[2:0];
  assign srl_w = {acc, 1'b0} >> opnd[2:0];

  always_comb begin
    alu_val  = acc;
    alu_c    = 1'b0;
    dst_acc  = 1'b0;
    dst_a    = 1'b0;
    dst_dptr = 1'b0;
    case (cmd.op)
      OP_MOV_ACC_A:  begin alu_val = opnd;          dst_acc  = 1'b1; end
      OP_MOV_A_ACC:  begin alu_val = acc;           dst_a    = 1'b1; end
      OP_MOV_DP_ACC: begin alu_val = acc;           dst_dptr = 1'b1; end
      OP_STM:        alu_val = acc;
      OP_INV:        begin alu_val = ~acc;          dst_acc  = 1'b1; end
      OP_AND:        begin alu_val = acc & opnd;    dst_acc  = 1'b1; end
      OP_OR:         begin alu_val = acc | opnd;    dst_acc  = 1'b1; end
      OP_XOR:        begin alu_val = acc ^ opnd;    dst_acc  = 1'b1; end
      OP_ADD: begin
        alu_val = add_w[7:0];
        alu_c   = add_w[8];
        dst_acc = 1'b1;
      end
      OP_SUB: begin
        // bit 8 of the difference is the borrow
        alu_val = sub_w[7:0];
        alu_c   = sub_w[8];
        dst_acc = 1'b1;
      end
      OP_SLL: begin
        alu_val = sll_w[7:0];
        alu_c   = sll_w[8];
        dst_acc = 1'b1;
      end
      OP_SRL: begin
        alu_val = srl_w[8:1];
        alu_c   = srl_w[0];
        dst_acc = 1'b1;
      end
      default: ;
    endcase
  end

  // architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= 8'h00;
      opnd        <= 8'h00;
      dptr        <= 8'h00;
      pc          <= 9'd0;
      flag_z      <= 1'b0;
      flag_n      <= 1'b0;
      flag_c      <= 1'b0;
      stop        <= STOP_NONE;
      op_reg      <= 8'h00;
      step_cnt    <= 16'd0;
      depth       <= '0;
      clr_cnt     <= '0;
      steps_limit <= MAX_STEPS_RST;
    end else begin
      if (cfg_valid) steps_limit <= max_steps;
      if (cmd.clr_step) clr_cnt <= clr_cnt + 1'b1;

      if (cmd.restart) begin
        acc      <= 8'h00;
        opnd     <= 8'h00;
        dptr     <= 8'h00;
        pc       <= 9'd0;
        flag_z   <= 1'b0;
        flag_n   <= 1'b0;
        flag_c   <= 1'b0;
        stop     <= STOP_NONE;
        op_reg   <= 8'h00;
        step_cnt <= 16'd0;
        depth    <= '0;
      end

      if (cmd.pc_inc)   pc <= pc + 9'd1;
      if (cmd.set_stop) stop <= cmd.stop_val;
      if (cmd.latch_op) op_reg <= mem_q;
      if (cmd.step_inc) step_cnt <= step_cnt + 16'd1;

      if (cmd.alu_exec) begin
        if (dst_acc)  acc  <= alu_val;
        if (dst_a)    opnd <= alu_val;
        if (dst_dptr) dptr <= alu_val;
        flag_z <= (alu_val == 8'h00);
        flag_n <= alu_val[7];
        flag_c <= alu_c;
      end

      // operand-byte instructions; mem_q holds the operand
      if (cmd.imm_exec) begin
        case (cmd.op)
          OP_LDI: acc <= mem_q;
          OP_JMP: pc  <= {1'b0, mem_q};
          OP_JZ:  if (flag_z) pc <= {1'b0, mem_q};
          OP_JN:  if (flag_n) pc <= {1'b0, mem_q};
          OP_JC:  if (flag_c) pc <= {1'b0, mem_q};
          OP_CALL: begin
            if (!stack_full) begin
              depth <= depth + 1'b1;
              pc    <= {1'b0, mem_q};
            end
          end
          default: ;
        endcase
      end

      if (cmd.load_acc) acc <= mem_q;
      if (cmd.pop)      depth <= depth_m1;
      if (cmd.ret_load) pc <= stack_q;
    end
  end

  // item latch (payload, no reset)
  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item_func  <= func_t'(func);
      item_addr  <= address;
      item_wdata <= write_data;
    end
  end

  // result word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.res_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // result word payload
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      accumulator   <= acc;
      operand_reg   <= opnd;
      data_pointer  <= dptr;
      prog_counter  <= pc;
      zero_flag     <= flag_z;
      negative_flag <= flag_n;
      carry_flag    <= flag_c;
      halted        <= (stop != STOP_NONE);
      stop_cause    <= stop;
      last_op       <= op_reg;
      read_data     <= (item_func == FUNC_READ) ? mem_q : 8'h00;
    end
  end

  // status to controller
  always_comb begin
    sts.func        = item_func;
    sts.mem_q       = mem_q;
    sts.last_op     = op_reg;
    sts.halted      = (stop != STOP_NONE);
    sts.step_limit  = (step_cnt >= steps_limit);
    sts.pc_oob      = pc[8];
    sts.stack_empty = (depth == '0);
    sts.stack_full  = stack_full;
    sts.out_busy    = result_valid && result_stall;
    sts.clr_last    = (clr_cnt == ADDR_W'(MEM_DEPTH - 1));
  end

endmodule

// ===== rtl/accumulator_cpu_8bit_core_top.sv =====
// ----------------------------------------------------------------------------
// accumulator_cpu_8bit_core_top
// 8-bit accumulator core with a 256-byte unified memory, a controller
// sequencer and a datapath.
//
//   channel  | direction | handshake                 | word
//   ---------+-----------+---------------------------+---------------------------
//   item     | in        | item_valid / item_stall   | func, address, write_data
//   result   | out       | result_valid / result_stall | registers, flags, status
//   cfg      | in        | cfg_valid / cfg_ready     | max_steps
//
// A word holds the core from its accepting cycle through the result load:
// write, read, restart and an execute stopped before the fetch pass S_DISPATCH
// and S_DONE; register ops, stores, a bad opcode, an empty-stack return or an
// operand fetch from 256 also pass S_OP; operand-byte, load and return ops pass
// S_OP and then S_IMM, S_LOAD or S_RET, as the memory has a single port.
// result_valid is registered from the result load. After reset the memory is
// cleared, one byte a cycle, with item_stall high; max_steps writes are taken
// throughout. A stalled result waits in the output register; the next item is
// accepted and worked meanwhile, and its result loads once the register is free.
// ----------------------------------------------------------------------------
module accumulator_cpu_8bit_core_top
  import acc8_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [1:0]        func,
  input  logic [ADDR_W-1:0] address,
  input  logic [7:0]        write_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       max_steps,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [7:0]        accumulator,
  output logic [7:0]        operand_reg,
  output logic [7:0]        data_pointer,
  output logic [8:0]        prog_counter,
  output logic              zero_flag,
  output logic              negative_flag,
  output logic              carry_flag,
  output logic              halted,
  output logic [2:0]        stop_cause,
  output logic [7:0]        last_op,
  output logic [7:0]        read_data
);

  cmd_t cmd;
  sts_t sts;

  // the limit register takes a write in any cycle
  assign cfg_ready = 1'b1;

  acc8_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  acc8_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .func          (func),
    .address       (address),
    .write_data    (write_data),
    .cfg_valid     (cfg_valid && cfg_ready),
    .max_steps     (max_steps),
    .cmd           (cmd),
    .sts           (sts),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .accumulator   (accumulator),
    .operand_reg   (operand_reg),
    .data_pointer  (data_pointer),
    .prog_counter  (prog_counter),
    .zero_flag     (zero_flag),
    .negative_flag (negative_flag),
    .carry_flag    (carry_flag),
    .halted        (halted),
    .stop_cause    (stop_cause),
    .last_op       (last_op),
    .read_data     (read_data)
  );

endmodule

// ===== sim/accumulator_cpu_8bit_core_top_tb.sv =====
// ----------------------------------------------------------------------------
// accumulator_cpu_8bit_core_top_tb
// Self-checking bench for the 8-bit accumulator core. A shadow copy of the
// core (registers, flags, memory, return stack, step counter) is advanced
// for every accepted word and yields the register view that the next result
// must show. Directed tests cover memory access, every opcode and each halt
// cause; random short programs with noise words then fill the run. Sender
// gaps and result stalls are drawn at random per word.
// ----------------------------------------------------------------------------
module accumulator_cpu_8bit_core_top_tb;
  import acc8_pkg::*;

  localparam int RET_SLOTS    = STACK_DEPTH_DEF;
  localparam int RANDOM_WORDS = 1250;
  localparam int TAIL_CYCLES  = 20;

  // register view carried by one result word
  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] opnd;
    logic [7:0] dptr;
    logic [8:0] pc;
    logic       z;
    logic       n;
    logic       c;
    logic       halt;
    logic [2:0] cause;
    logic [7:0] op;
    logic [7:0] rdata;
  } cpu_view_t;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  logic [1:0]  func;
  logic [7:0]  address;
  logic [7:0]  write_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] max_steps;
  logic        result_valid;
  logic        result_stall;
  logic [7:0]  accumulator;
  logic [7:0]  operand_reg;
  logic [7:0]  data_pointer;
  logic [8:0]  prog_counter;
  logic        zero_flag;
  logic        negative_flag;
  logic        carry_flag;
  logic        halted;
  logic [2:0]  stop_cause;
  logic [7:0]  last_op;
  logic [7:0]  read_data;

  // shadow core state
  logic [7:0]  sh_mem [MEM_DEPTH];
  logic [8:0]  sh_stack [RET_SLOTS];
  int          sh_depth;
  logic [7:0]  sh_acc, sh_a, sh_dptr, sh_last;
  logic [8:0]  sh_pc;
  logic        sh_z, sh_n, sh_c;
  stop_t       sh_stop;
  logic [15:0] sh_steps, sh_limit;

  cpu_view_t   views_due [$];
  int          words_sent;
  int          mismatches;
  bit          calm;

  accumulator_cpu_8bit_core_top #(
    .STACK_DEPTH(RET_SLOTS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .func         (func),
    .address      (address),
    .write_data   (write_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .max_steps    (max_steps),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .accumulator  (accumulator),
    .operand_reg  (operand_reg),
    .data_pointer (data_pointer),
    .prog_counter (prog_counter),
    .zero_flag    (zero_flag),
    .negative_flag(negative_flag),
    .carry_flag   (carry_flag),
    .halted       (halted),
    .stop_cause   (stop_cause),
    .last_op      (last_op),
    .read_data    (read_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // ---------------------------------------------------------------- shadow core

  function automatic void clear_shadow_regs();
    sh_acc   = '0;
    sh_a     = '0;
    sh_dptr  = '0;
    sh_last  = '0;
    sh_pc    = '0;
    sh_z     = 1'b0;
    sh_n     = 1'b0;
    sh_c     = 1'b0;
    sh_stop  = STOP_NONE;
    sh_steps = '0;
    sh_depth = 0;
  endfunction

  function automatic void set_shadow_flags(input logic [7:0] v, input logic cy);
    sh_z = (v == 8'd0);
    sh_n = v[7];
    sh_c = cy;
  endfunction

  // operand byte at pc; a pc of 256 halts the core instead
  function automatic logic fetch_imm(output logic [7:0] v);
    v = '0;
    if (sh_pc[8]) begin
      sh_stop = STOP_PC_RANGE;
      return 1'b0;
    end
    v = sh_mem[sh_pc[7:0]];
    sh_pc = sh_pc + 9'd1;
    return 1'b1;
  endfunction

  // advance the shadow core by one word and return the view it must report
  function automatic cpu_view_t shadow_step(input logic [1:0] f, input logic [7:0] ad,
                                            input logic [7:0] wd);
    cpu_view_t  v;
    logic [7:0] op;
    logic [7:0] imm;
    logic [8:0] sum;
    logic [2:0] sh;
    logic       cy;
    v = '0;
    case (f)
      FUNC_WRITE:   sh_mem[ad] = wd;
      FUNC_READ:    v.rdata = sh_mem[ad];
      FUNC_RESTART: clear_shadow_regs();
      default: begin
        // execute one instruction unless already stopped
        if (sh_stop != STOP_NONE) begin
        end else if (sh_steps >= sh_limit) begin
          sh_stop = STOP_STEPS;
        end else if (sh_pc[8]) begin
          sh_stop = STOP_PC_RANGE;
        end else begin
          op      = sh_mem[sh_pc[7:0]];
          sh_pc   = sh_pc + 9'd1;
          sh_last = op;
          if (op[2:0] != 3'b000 || op < OP_MOV_ACC_A || op > OP_SUB) begin
            sh_stop = STOP_BAD_OP;
          end else begin
            sh_steps = sh_steps + 16'd1;
            case (op)
              OP_MOV_ACC_A: begin
                sh_acc = sh_a;
                set_shadow_flags(sh_acc, 1'b0);
              end
              OP_MOV_A_ACC: begin
                sh_a = sh_acc;
                set_shadow_flags(sh_a, 1'b0);
              end
              OP_LDI: if (fetch_imm(imm)) sh_acc = imm;
              OP_LDM: sh_acc = sh_mem[sh_dptr];
              OP_MOV_DP_ACC: begin
                sh_dptr = sh_acc;
                set_shadow_flags(sh_dptr, 1'b0);
              end
              OP_STM: begin
                sh_mem[sh_dptr] = sh_acc;
                set_shadow_flags(sh_acc, 1'b0);
              end
              OP_INV: begin
                sh_acc = ~sh_acc;
                set_shadow_flags(sh_acc, 1'b0);
              end
              OP_AND: begin
                sh_acc = sh_acc & sh_a;
                set_shadow_flags(sh_acc, 1'b0);
              end
              OP_ADD: begin
                sum    = {1'b0, sh_acc} + {1'b0, sh_a};
                sh_acc = sum[7:0];
                set_shadow_flags(sh_acc, sum[8]);
              end
              // JMP reads its target in place, pc never steps past it
              OP_JMP: begin
                if (sh_pc[8]) sh_stop = STOP_PC_RANGE;
                else sh_pc = {1'b0, sh_mem[sh_pc[7:0]]};
              end
              OP_JZ: if (fetch_imm(imm) && sh_z) sh_pc = {1'b0, imm};
              OP_JN: if (fetch_imm(imm) && sh_n) sh_pc = {1'b0, imm};
              OP_JC: if (fetch_imm(imm) && sh_c) sh_pc = {1'b0, imm};
              OP_CALL: begin
                if (fetch_imm(imm)) begin
                  if (sh_depth >= RET_SLOTS) begin
                    sh_stop = STOP_OVERFLOW;
                  end else begin
                    sh_stack[sh_depth] = sh_pc;
                    sh_depth = sh_depth + 1;
                    sh_pc = {1'b0, imm};
                  end
                end
              end
              OP_RET: begin
                if (sh_depth == 0) begin
                  sh_stop = STOP_RET_EMPTY;
                end else begin
                  sh_depth = sh_depth - 1;
                  sh_pc = sh_stack[sh_depth];
                end
              end
              OP_XOR: begin
                sh_acc = sh_acc ^ sh_a;
                set_shadow_flags(sh_acc, 1'b0);
              end
              // shifts by A mod 8; carry is the last bit shifted out
              OP_SLL: begin
                sh = sh_a[2:0];
                cy = 1'b0;
                if (sh != 3'd0) begin
                  cy = sh_acc[8 - sh];
                  sh_acc = sh_acc << sh;
                end
                set_shadow_flags(sh_acc, cy);
              end
              OP_SRL: begin
                sh = sh_a[2:0];
                cy = 1'b0;
                if (sh != 3'd0) begin
                  cy = sh_acc[sh - 1];
                  sh_acc = sh_acc >> sh;
                end
                set_shadow_flags(sh_acc, cy);
              end
              OP_OR: begin
                sh_acc = sh_acc | sh_a;
                set_shadow_flags(sh_acc, 1'b0);
              end
              OP_SUB: begin
                cy = (sh_acc < sh_a);
                sh_acc = sh_acc - sh_a;
                set_shadow_flags(sh_acc, cy);
              end
              default: ;
            endcase
          end
        end
      end
    endcase
    v.acc   = sh_acc;
    v.opnd  = sh_a;
    v.dptr  = sh_dptr;
    v.pc    = sh_pc;
    v.z     = sh_z;
    v.n     = sh_n;
    v.c     = sh_c;
    v.halt  = (sh_stop != STOP_NONE);
    v.cause = sh_stop;
    v.op    = sh_last;
    return v;
  endfunction

  function automatic string show_view(input cpu_view_t v);
    return $sformatf("acc=%h a=%h dp=%h pc=%h z=%b n=%b c=%b halt=%b cause=%0d op=%h rd=%h",
                     v.acc, v.opnd, v.dptr, v.pc, v.z, v.n, v.c, v.halt, v.cause,
                     v.op, v.rdata);
  endfunction

  function automatic logic [7:0] opcode_at(input int k);
    case (k)
      0:       return OP_MOV_ACC_A;
      1:       return OP_MOV_A_ACC;
      2:       return OP_LDI;
      3:       return OP_LDM;
      4:       return OP_MOV_DP_ACC;
      5:       return OP_STM;
      6:       return OP_INV;
      7:       return OP_AND;
      8:       return OP_ADD;
      9:       return OP_JMP;
      10:      return OP_JZ;
      11:      return OP_JN;
      12:      return OP_JC;
      13:      return OP_CALL;
      14:      return OP_RET;
      15:      return OP_XOR;
      16:      return OP_SLL;
      17:      return OP_SRL;
      18:      return OP_OR;
      default: return OP_SUB;
    endcase
  endfunction

  function automatic logic takes_operand(input logic [7:0] op);
    return op == OP_LDI || op == OP_JMP || op == OP_JZ || op == OP_JN ||
           op == OP_JC || op == OP_CALL;
  endfunction

  // ---------------------------------------------------------------- result side

  // random stall ahead of each result word
  initial begin : result_pacer
    int hold;
    result_stall = 1'b0;
    forever begin
      hold = calm ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (rst || result_valid !== 1'b1 || result_stall);
    end
  end

  // compare each accepted result word with the oldest predicted view
  always @(posedge clk) begin
    cpu_view_t got;
    cpu_view_t want;
    if (!rst && result_valid && !result_stall) begin
      got = {accumulator, operand_reg, data_pointer, prog_counter, zero_flag,
             negative_flag, carry_flag, halted, stop_cause, last_op, read_data};
      if (views_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result at %0t: %s", $time, show_view(got));
      end else begin
        want = views_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: expected %s", $time, show_view(want));
            $display("                 got      %s", show_view(got));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- item side

  task automatic send_word(input logic [1:0] f, input logic [7:0] ad, input logic [7:0] wd);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    func       <= f;
    address    <= ad;
    write_data <= wd;
    do @(posedge clk); while (item_stall);
    views_due.insert(views_due.size(), shadow_step(f, ad, wd));
    words_sent++;
  endtask

  // hold the sender until every predicted result has come back
  task automatic drain_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (views_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_step_limit(input logic [15:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    max_steps <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sh_limit = v;
    @(posedge clk);
  endtask

  task automatic load_bytes(input logic [7:0] base, input logic [7:0] image [$]);
    foreach (image[i]) send_word(FUNC_WRITE, base + 8'(i), image[i]);
  endtask

  // execute until the shadow core stops (or the cap), then once more
  task automatic run_until_halt(input int cap, input bit noisy);
    int n;
    n = 0;
    while (sh_stop == STOP_NONE && n < cap) begin
      if (noisy && $urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 7))
          0, 1, 2, 3: send_word(FUNC_READ, 8'($urandom), 8'($urandom));
          4, 5, 6:    send_word(FUNC_WRITE, 8'($urandom), 8'($urandom));
          default:    send_word(FUNC_RESTART, 8'($urandom), 8'($urandom));
        endcase
      end
      send_word(FUNC_EXEC, 8'($urandom), 8'($urandom));
      n++;
    end
    send_word(FUNC_EXEC, 8'($urandom), 8'($urandom));
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_memory_access();
    send_word(FUNC_WRITE, 8'h00, 8'hFF);
    send_word(FUNC_WRITE, 8'hFF, 8'h5A);
    send_word(FUNC_WRITE, 8'hA5, 8'h00);
    send_word(FUNC_READ, 8'h00, 8'h00);
    send_word(FUNC_READ, 8'hFF, 8'hFF);
    send_word(FUNC_READ, 8'hA5, 8'h00);
    send_word(FUNC_READ, 8'h3C, 8'hC3);  // never written, still clear
  endtask

  // one program that walks through all twenty opcodes, ends on RET with
  // an empty stack, then one execute while halted
  task automatic test_all_opcodes();
    logic [7:0] image [$];
    set_step_limit(MAX_STEPS_RST);
    image = '{OP_LDI, 8'hF0, OP_MOV_A_ACC, OP_LDI, 8'h23, OP_ADD, OP_JC, 8'h09,
              8'hFF, OP_SUB, OP_INV, OP_AND, OP_XOR, OP_OR, OP_SLL, OP_JN, 8'h12,
              8'h00, OP_MOV_ACC_A, OP_LDI, 8'h03, OP_MOV_A_ACC, OP_LDI, 8'h85,
              OP_SLL, OP_SRL, OP_LDI, 8'h80, OP_MOV_DP_ACC, OP_STM, OP_LDM,
              OP_CALL, 8'h30, OP_JMP, 8'h40};
    load_bytes(8'h00, image);
    image = '{OP_JZ, 8'h34, OP_RET, 8'h00, OP_RET};
    load_bytes(8'h30, image);
    send_word(FUNC_WRITE, 8'h40, OP_RET);
    send_word(FUNC_RESTART, 8'h00, 8'h00);
    run_until_halt(60, 1'b0);
  endtask

  // step limits of 1 and 3; memory access still works while halted
  task automatic test_step_limit();
    set_step_limit(16'd1);
    send_word(FUNC_RESTART, 8'hFF, 8'hFF);
    run_until_halt(5, 1'b0);
    send_word(FUNC_WRITE, 8'hC0, 8'h3C);
    send_word(FUNC_READ, 8'hC0, 8'h00);
    set_step_limit(16'd3);
    send_word(FUNC_RESTART, 8'h00, 8'h00);
    run_until_halt(8, 1'b0);
  endtask

  // pc at 256 on fetch, operand fetch from 256, JMP operand at 256
  task automatic test_pc_range();
    logic [7:0] image [$];
    set_step_limit(MAX_STEPS_RST);
    image = '{OP_JMP, 8'hFF};
    load_bytes(8'h00, image);
    send_word(FUNC_WRITE, 8'hFF, OP_MOV_ACC_A);
    send_word(FUNC_RESTART, 8'h00, 8'h00);
    run_until_halt(5, 1'b0);
    send_word(FUNC_WRITE, 8'hFF, OP_LDI);
    send_word(FUNC_RESTART, 8'h00, 8'h00);
    run_until_halt(5, 1'b0);
    send_word(FUNC_WRITE, 8'hFF, OP_JMP);
    send_word(FUNC_RESTART, 8'h00, 8'h00);
    run_until_halt(5, 1'b0);
  endtask

  // a CALL to itself fills the return stack and then overflows
  task automatic test_stack_overflow();
    logic [7:0] image [$];
    image = '{OP_JMP, 8'h60};
    load_bytes(8'h00, image);
    image = '{OP_CALL, 8'h60};
    load_bytes(8'h60, image);
    send_word(FUNC_RESTART, 8'h00, 8'h00);
    run_until_halt(RET_SLOTS + 8, 1'b0);
  endtask

  // aligned byte just past the opcode table, and the all-zero byte
  task automatic test_bad_opcode();
    send_word(FUNC_WRITE, 8'h00, 8'hA8);
    send_word(FUNC_RESTART, 8'h00, 8'h00);
    run_until_halt(3, 1'b0);
    send_word(FUNC_WRITE, 8'h00, 8'h00);
    send_word(FUNC_RESTART, 8'h00, 8'h00);
    run_until_halt(3, 1'b0);
  endtask

  // short random programs, jump targets mostly inside the program
  task automatic test_random_programs();
    logic [7:0] image [$];
    logic [7:0] op;
    int         len;
    int         start;
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 7))
        0:       set_step_limit(16'($urandom_range(1, 4)));
        1:       set_step_limit(16'($urandom_range(5, 40)));
        2:       set_step_limit(MAX_STEPS_RST);
        default: ;
      endcase
      len = $urandom_range(4, 30);
      image.delete();
      while (image.size() < len) begin
        op = ($urandom_range(0, 19) == 0) ? 8'($urandom) : opcode_at($urandom_range(0, 19));
        image.insert(image.size(), op);
        if (takes_operand(op)) begin
          if (op == OP_LDI || $urandom_range(0, 7) == 0)
            image.insert(image.size(), 8'($urandom));
          else
            image.insert(image.size(), 8'($urandom_range(0, len - 1)));
        end
      end
      send_word(FUNC_RESTART, 8'($urandom), 8'($urandom));
      load_bytes(8'h00, image);
      run_until_halt($urandom_range(6, 40), 1'b1);
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin : main_seq
    rst        = 1'b1;
    item_valid = 1'b0;
    func       = FUNC_WRITE;
    address    = '0;
    write_data = '0;
    cfg_valid  = 1'b0;
    max_steps  = MAX_STEPS_RST;
    calm       = 1'b0;
    words_sent = 0;
    mismatches = 0;
    clear_shadow_regs();
    foreach (sh_mem[i]) sh_mem[i] = '0;
    sh_limit = MAX_STEPS_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_memory_access();
    test_all_opcodes();
    test_step_limit();
    test_pc_range();
    test_stack_overflow();
    test_bad_opcode();
    test_random_programs();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && views_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== accumulator_cpu_8bit_core_top.f =====
+incdir+rtl
rtl/acc8_pkg.sv
rtl/acc8_ctrl.sv
rtl/acc8_dp.sv
rtl/accumulator_cpu_8bit_core_top.sv
sim/accumulator_cpu_8bit_core_top_tb.sv
